### sv/mct_pkg.sv
// Shared types and constants for the 4x4 matrix column transform core.
// Used by mct_row_mac and matrix4_column_transform_core; no dependencies.
`timescale 1ns / 1ps

package mct_pkg;

   // Fixed-point format and matrix geometry
   localparam int FRAC_BITS = 16;
   localparam int DIM       = 4;
   localparam int FIX_W     = 32;
   localparam int PROD_W    = 2 * FIX_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + 2;

   // Register file geometry
   localparam int NUM_REGS  = 8;
   localparam int REG_W     = 2 * FIX_W;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int CSR_IDX_W = REG_IDX_W + 1;

   typedef logic signed [FIX_W-1:0]  fix_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [REG_W-1:0]         reg_type;

   // Saturation limits of the result format
   localparam fix_type FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
   localparam fix_type FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};

   // Reset contents: the identity matrix, column-major, two rows per register
   localparam reg_type ONE_LO = reg_type'(64'd1) << FRAC_BITS;
   localparam reg_type ONE_HI = reg_type'(64'd1) << (FRAC_BITS + FIX_W);

   function automatic reg_type reg_reset_value(input logic [REG_IDX_W-1:0] idx);
      reg_type val;
      val = '0;
      unique case (idx)
         3'd0:    val = ONE_LO;
         3'd2:    val = ONE_HI;
         3'd5:    val = ONE_LO;
         3'd7:    val = ONE_HI;
         default: val = '0;
      endcase
      return val;
   endfunction

   // Load enables for the three pipeline register stages
   typedef struct packed {
      logic ld_mul;
      logic ld_add;
      logic ld_out;
   } pipe_ctl_type;

endpackage

### sv/matrix4_column_transform_core.sv
// Channel   | Direction | Ports                                        | Transfer when
// ----------+-----------+----------------------------------------------+---------------------
// request   | in        | req_valid, req_stall, req_vec_x/y/z/w        | valid && !stall
// response  | out       | rsp_valid, rsp_stall, rsp_out_x/y/z/w, rsp_saturated | valid && !stall
// csr       | in        | csr_write_en, csr_index, csr_wdata           | csr_write_en
//
// A transferred request reaches response valid through the stages below; one item per cycle while rsp_stall is low.
// The three stages are multiply, pairwise add, and final add with floor shift and clip.
// Each stage holds only when its successor is full and stalled, so bubbles collapse.
// Synchronous reset empties the pipeline and loads the identity matrix.
// Top level of the 4x4 matrix times column vector core; depends on mct_pkg, mct_row_mac.
`timescale 1ns / 1ps

module matrix4_column_transform_core (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  mct_pkg::fix_type                 req_vec_x,
   input  mct_pkg::fix_type                 req_vec_y,
   input  mct_pkg::fix_type                 req_vec_z,
   input  mct_pkg::fix_type                 req_vec_w,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mct_pkg::fix_type                 rsp_out_x,
   output mct_pkg::fix_type                 rsp_out_y,
   output mct_pkg::fix_type                 rsp_out_z,
   output mct_pkg::fix_type                 rsp_out_w,
   output logic                             rsp_saturated,
   // configuration
   input  logic                             csr_write_en,
   input  logic [mct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  mct_pkg::reg_type                 csr_wdata
);

   mct_pkg::reg_type     regs_ff [mct_pkg::NUM_REGS];
   mct_pkg::fix_type     vec     [mct_pkg::DIM];
   mct_pkg::fix_type     row_val [mct_pkg::DIM];
   logic [mct_pkg::DIM-1:0] row_sat;
   mct_pkg::pipe_ctl_type ctl;
   logic                 v1_ff, v2_ff, v3_ff;
   logic                 rdy1, rdy2, rdy3;

   // Matrix registers; indexes past the last register are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mct_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= mct_pkg::reg_reset_value(mct_pkg::REG_IDX_W'(i));
         end
      end else if (csr_write_en && !csr_index[mct_pkg::CSR_IDX_W-1]) begin
         regs_ff[csr_index[mct_pkg::REG_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // Stage readiness: a stage may load when empty or when its successor moves
   always_comb begin
      rdy3       = !v3_ff || !rsp_stall;
      rdy2       = !v2_ff || rdy3;
      rdy1       = !v1_ff || rdy2;
      ctl.ld_mul = rdy1;
      ctl.ld_add = rdy2;
      ctl.ld_out = rdy3;
   end

   // Advance valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   assign vec[0] = req_vec_x;
   assign vec[1] = req_vec_y;
   assign vec[2] = req_vec_z;
   assign vec[3] = req_vec_w;

   // One multiply-accumulate row per output component
   for (genvar r = 0; r < mct_pkg::DIM; r++) begin : g_row
      mct_pkg::fix_type coef [mct_pkg::DIM];
      for (genvar c = 0; c < mct_pkg::DIM; c++) begin : g_col
         assign coef[c] = regs_ff[2*c + (r >> 1)][(r & 1)*mct_pkg::FIX_W +: mct_pkg::FIX_W];
      end
      mct_row_mac u_row (
         .clock   (clock),
         .ctl     (ctl),
         .coef    (coef),
         .vec     (vec),
         .row_out (row_val[r]),
         .row_sat (row_sat[r])
      );
   end

   assign req_stall     = !rdy1;
   assign rsp_valid     = v3_ff;
   assign rsp_out_x     = row_val[0];
   assign rsp_out_y     = row_val[1];
   assign rsp_out_z     = row_val[2];
   assign rsp_out_w     = row_val[3];
   assign rsp_saturated = |row_sat;

endmodule

### sv/mct_row_mac.sv
// One output row of the transform: four products, pairwise sums, final sum,
// floor shift and saturation, over three register stages. Depends on mct_pkg.
`timescale 1ns / 1ps

module mct_row_mac (
   input  logic                  clock,
   input  mct_pkg::pipe_ctl_type ctl,
   input  mct_pkg::fix_type      coef [mct_pkg::DIM],
   input  mct_pkg::fix_type      vec  [mct_pkg::DIM],
   output mct_pkg::fix_type      row_out,
   output logic                  row_sat
);

   mct_pkg::prod_type prod_ff [mct_pkg::DIM];
   mct_pkg::pair_type pair_ff [2];
   mct_pkg::pair_type pair_in [2];
   mct_pkg::sum_type  sum_in;
   mct_pkg::sum_type  shifted_in;
   mct_pkg::fix_type  row_ff;
   mct_pkg::fix_type  row_in;
   logic              sat_ff;
   logic              sat_in;
   logic [mct_pkg::SUM_W-mct_pkg::FIX_W:0] top_bits;

   // Stage 1: one 32x32 signed multiply per column
   always_ff @(posedge clock) begin
      if (ctl.ld_mul) begin
         for (int c = 0; c < mct_pkg::DIM; c++) begin
            prod_ff[c] <= mct_pkg::prod_type'(coef[c] * vec[c]);
         end
      end
   end

   // Stage 2: pairwise sums
   always_comb begin
      pair_in[0] = mct_pkg::pair_type'(prod_ff[0]) + mct_pkg::pair_type'(prod_ff[1]);
      pair_in[1] = mct_pkg::pair_type'(prod_ff[2]) + mct_pkg::pair_type'(prod_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_add) begin
         pair_ff <= pair_in;
      end
   end

   // Stage 3: exact sum, drop fraction bits (floor), clip to 32 bits
   always_comb begin
      sum_in     = mct_pkg::sum_type'(pair_ff[0]) + mct_pkg::sum_type'(pair_ff[1]);
      shifted_in = sum_in >>> mct_pkg::FRAC_BITS;
      top_bits   = shifted_in[mct_pkg::SUM_W-1:mct_pkg::FIX_W-1];
      if ((&top_bits) || !(|top_bits)) begin
         row_in = shifted_in[mct_pkg::FIX_W-1:0];
         sat_in = 1'b0;
      end else if (shifted_in[mct_pkg::SUM_W-1]) begin
         row_in = mct_pkg::FIX_MIN;
         sat_in = 1'b1;
      end else begin
         row_in = mct_pkg::FIX_MAX;
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_out) begin
         row_ff <= row_in;
         sat_ff <= sat_in;
      end
   end

   assign row_out = row_ff;
   assign row_sat = sat_ff;

endmodule

### sv/mct_checker.sv
// Port-level checks for matrix4_column_transform_core, bound to the top level.
// Depends on mct_pkg and matrix4_column_transform_core.
`timescale 1ns / 1ps

module mct_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input mct_pkg::fix_type              rsp_out_x,
   input mct_pkg::fix_type              rsp_out_y,
   input mct_pkg::fix_type              rsp_out_z,
   input mct_pkg::fix_type              rsp_out_w,
   input logic                          rsp_saturated
);

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Empty pipeline right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Drain: free cycles without new input that flush every stage leave nothing behind
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!req_xfer && !rsp_stall) ##1 (!req_xfer && !rsp_stall) ##1
      (!req_xfer && !rsp_stall) |=> !rsp_valid)
      else $error("response appeared without a request");

   // A clipped result shows at least one component at a limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_out_x == mct_pkg::FIX_MAX || rsp_out_x == mct_pkg::FIX_MIN ||
         rsp_out_y == mct_pkg::FIX_MAX || rsp_out_y == mct_pkg::FIX_MIN ||
         rsp_out_z == mct_pkg::FIX_MAX || rsp_out_z == mct_pkg::FIX_MIN ||
         rsp_out_w == mct_pkg::FIX_MAX || rsp_out_w == mct_pkg::FIX_MIN)
      else $error("saturated flag without a clipped component");

endmodule

bind matrix4_column_transform_core mct_checker u_mct_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_x     (rsp_out_x),
   .rsp_out_y     (rsp_out_y),
   .rsp_out_z     (rsp_out_z),
   .rsp_out_w     (rsp_out_w),
   .rsp_saturated (rsp_saturated)
);
